// ===== hdl/vkt_pkg.sv =====
// ---------------------------------------------------------------------------
// vkt_pkg: shared types and constants for the turbulence filter bank
// Word types, request and status types of the multiply-divide unit, and filter constants.
// ---------------------------------------------------------------------------
`default_nettype none

package vkt_pkg;

   // Input word
   typedef struct packed {
      logic [22:0]        tau_horizontal;
      logic [22:0]        tau_vertical;
      logic [21:0]        gain_long;
      logic [21:0]        gain_lat;
      logic [21:0]        gain_vert;
      logic signed [31:0] noise_long;
      logic signed [31:0] noise_lat;
      logic signed [31:0] noise_vert;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] turb_long;
      logic signed [31:0] turb_lat;
      logic signed [31:0] turb_vert;
   } rsp_word_type;

   // Q16.16 constants, rounded to nearest
   localparam logic signed [63:0] Q_ONE     = 64'sd65536;
   localparam logic signed [63:0] C_LONG_A2 = 64'sd13022;
   localparam logic signed [63:0] C_LONG_A1 = 64'sd88932;
   localparam logic signed [63:0] C_LONG_B1 = 64'sd16384;
   localparam logic signed [63:0] C_LAT_D3  = 64'sd10086;
   localparam logic signed [63:0] C_LAT_D2  = 64'sd129460;
   localparam logic signed [63:0] C_LAT_D1  = 64'sd196333;
   localparam logic signed [63:0] C_LAT_N1  = 64'sd180080;
   localparam logic signed [63:0] C_LAT_N2  = 64'sd22269;
   localparam logic signed [63:0] BIG       = 64'sh7FFF_FFFF_FFFF_FFFF;

   // Request to the bit-serial multiply-divide unit
   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic        [63:0] d;
   } md_req_type;

   // Status back from the unit
   typedef struct packed {
      logic               done;
      logic signed [63:0] q;
   } md_rsp_type;

   // Saturating add to +-(2^63-1)
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, BIG})) return BIG;
      if (s < -$signed({1'b0, BIG})) return -BIG;
      return s[63:0];
   endfunction

   // Negate with the +-(2^63-1) bound
   function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
      if (a < -BIG) return BIG;
      return -a;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/vkt_muldiv.sv =====
// ---------------------------------------------------------------------------
// vkt_muldiv: bit-serial multiply then divide
// Forms |a|*|b| one bit a cycle into 128 bits, then restoring division by d
// one quotient bit a cycle; truncates toward zero, saturates to 2^63-1.
// ---------------------------------------------------------------------------
`default_nettype none

module vkt_muldiv (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vkt_pkg::md_req_type md_req,
   output vkt_pkg::md_rsp_type      md_rsp
);
   import vkt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [6:0]   count_ff, count_in;
   logic [63:0]  mcand_ff, mcand_in;   // multiplicand, held
   logic [63:0]  mplier_ff, mplier_in; // multiplier, shifted right
   logic [127:0] prod_ff, prod_in;
   logic [63:0]  div_ff, div_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic         neg_ff, neg_in;
   logic         ovf_ff, ovf_in;
   logic [64:0]  trial;
   logic [64:0]  psum;
   logic [63:0]  mag;

   always_comb begin
      trial = {rem_ff, prod_ff[127]};
      psum = {1'b0, prod_ff[127:64]} + (mplier_ff[0] ? {1'b0, mcand_ff} : 65'd0);
      mag = ovf_ff ? 64'hFFFF_FFFF_FFFF_FFFF : quo_ff;
      if (mag > BIG) mag = BIG;
   end

   // Sequence the shift-add then shift-subtract passes
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (md_req.start) begin
               mcand_in  = md_req.a[63] ? 64'(-md_req.a) : md_req.a;
               mplier_in = md_req.b[63] ? 64'(-md_req.b) : md_req.b;
               neg_in    = md_req.a[63] ^ md_req.b[63];
               div_in    = (md_req.d == 64'd0) ? 64'd1 : md_req.d;
               prod_in   = '0;
               count_in  = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            // add the multiplicand into the high half when the multiplier's low bit is set, then shift right
            prod_in   = {psum, prod_ff[63:1]};
            mplier_in = mplier_ff >> 1;
            count_in  = count_ff + 7'd1;
            if (count_ff == 7'd63) begin
               state_in = S_DIV;
               count_in = '0;
            end
         end
         S_DIV: begin
            if (count_ff == 7'd0) begin
               // high half at or above divisor: quotient overflows
               ovf_in = (prod_ff[127:64] >= div_ff);
               rem_in = prod_ff[127:64];
               prod_in = {prod_ff[63:0], 64'd0};
               quo_in = '0;
               count_in = 7'd1;
            end else begin
               if (trial >= {1'b0, div_ff}) begin
                  rem_in = 64'(trial - {1'b0, div_ff});
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = trial[63:0];
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               prod_in  = prod_ff << 1;
               count_in = count_ff + 7'd1;
               if (count_ff == 7'd64) state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
   end

   assign md_rsp.done = (state_ff == S_DONE);
   assign md_rsp.q    = neg_ff ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// ===== hdl/von_karman_turbulence_filter_bank.sv =====
// ---------------------------------------------------------------------------
// von_karman_turbulence_filter_bank: three-axis turbulence shaping filter bank
// Each accepted word runs 41 multiply-divides in turn on one shared bit-serial unit;
// no new word is taken until the finished one is loaded into the output register.
// Synchronous reset clears filter states, sets the substep length dt_ff to 66, empties channels.
// ---------------------------------------------------------------------------
`default_nettype none

module von_karman_turbulence_filter_bank #(
   parameter int STATE_WIDTH = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire vkt_pkg::req_word_type req_word,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      vkt_pkg::rsp_word_type rsp_word,
   input  wire logic                  csr_write,
   input  wire logic [15:0]           csr_data
);
   import vkt_pkg::*;

   localparam logic signed [63:0] SMAX = 64'((65'sd1 <<< (STATE_WIDTH - 1)) - 65'sd1);
   localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

   typedef enum logic [3:0] {
      P_IDLE = 4'b0001,
      P_ISSUE = 4'b0010,
      P_WAIT = 4'b0100,
      P_OUT  = 4'b1000
   } phase_type;

   // step codes of the per-word program
   localparam int NSTEP = 41;

   phase_type          phase_ff, phase_in;
   logic [5:0]         step_ff, step_in;
   logic [15:0]        dt_ff;
   req_word_type       word_ff;
   rsp_word_type       out_ff;
   logic               out_valid_ff;
   logic signed [STATE_WIDTH-1:0] xs_ff [8];
   logic signed [63:0] t_ff [12];  // scratch registers
   logic signed [63:0] res;
   logic signed [63:0] wb;
   md_req_type         md_req;
   md_rsp_type         md_rsp;
   logic signed [63:0] a_sel, b_sel, d_sel;
   logic [3:0]         dst_sel;
   logic               take;
   logic               load_out;

   vkt_muldiv u_md (.clock(clock), .reset(reset), .md_req(md_req), .md_rsp(md_rsp));

   function automatic logic signed [63:0] clampst(input logic signed [63:0] v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic logic signed [63:0] floor1(input logic signed [63:0] v);
      return (v < 64'sd1) ? 64'sd1 : v;
   endfunction

   function automatic logic signed [63:0] to_out(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] sx(input logic signed [STATE_WIDTH-1:0] v);
      return 64'(v);
   endfunction

   // Scratch map: 0 tau2 1 a2 2 product 3 num/deriv 4 n0 5 n1 6 y 7 tau3
   //              8 d3 9 d2 10 d1 11 product
   logic signed [63:0] tauh, tauv, dt, gl, gla, gv;
   assign tauh = 64'(word_ff.tau_horizontal);
   assign tauv = 64'(word_ff.tau_vertical);
   assign dt   = 64'(dt_ff);
   assign gl   = 64'(word_ff.gain_long);
   assign gla  = 64'(word_ff.gain_lat);
   assign gv   = 64'(word_ff.gain_vert);

   // Operand select per program step: result into t[dst], with fixups below
   always_comb begin
      a_sel = '0; b_sel = '0; d_sel = Q_ONE; dst_sel = '0;
      unique case (step_ff)
         // longitudinal axis
         6'd0:  begin a_sel = tauh; b_sel = tauh; dst_sel = 4'd0; end
         6'd1:  begin a_sel = C_LONG_A2; b_sel = t_ff[0]; dst_sel = 4'd1; end
         6'd2:  begin a_sel = C_LONG_A1; b_sel = tauh; dst_sel = 4'd2; end
         6'd3:  begin a_sel = t_ff[2]; b_sel = sx(xs_ff[1]); dst_sel = 4'd3; end
         6'd4:  begin a_sel = t_ff[3]; b_sel = Q_ONE; d_sel = t_ff[1]; dst_sel = 4'd3; end
         6'd5:  begin a_sel = sx(xs_ff[1]); b_sel = dt; dst_sel = 4'd4; end
         6'd6:  begin a_sel = t_ff[3]; b_sel = dt; dst_sel = 4'd5; end
         6'd7:  begin a_sel = C_LONG_B1; b_sel = tauh; dst_sel = 4'd2; end
         6'd8:  begin a_sel = t_ff[2]; b_sel = sx(xs_ff[1]); dst_sel = 4'd6; end
         6'd9:  begin a_sel = gl; b_sel = t_ff[6]; d_sel = t_ff[1]; dst_sel = 4'd6; end
         // lateral axis (tau horizontal), steps 10..24
         6'd10: begin a_sel = t_ff[0]; b_sel = tauh; dst_sel = 4'd7; end
         6'd11: begin a_sel = C_LAT_D3; b_sel = t_ff[7]; dst_sel = 4'd8; end
         6'd12: begin a_sel = C_LAT_D2; b_sel = t_ff[0]; dst_sel = 4'd9; end
         6'd13: begin a_sel = C_LAT_D1; b_sel = tauh; dst_sel = 4'd10; end
         6'd14: begin a_sel = t_ff[10]; b_sel = sx(xs_ff[3]); dst_sel = 4'd2; end
         6'd15: begin a_sel = t_ff[9]; b_sel = sx(xs_ff[4]); dst_sel = 4'd3; end
         6'd16: begin a_sel = t_ff[3]; b_sel = Q_ONE; d_sel = t_ff[8]; dst_sel = 4'd3; end
         6'd17: begin a_sel = sx(xs_ff[3]); b_sel = dt; dst_sel = 4'd4; end
         6'd18: begin a_sel = sx(xs_ff[4]); b_sel = dt; dst_sel = 4'd5; end
         6'd19: begin a_sel = t_ff[3]; b_sel = dt; dst_sel = 4'd3; end
         6'd20: begin a_sel = C_LAT_N1; b_sel = tauh; dst_sel = 4'd2; end
         6'd21: begin a_sel = t_ff[2]; b_sel = sx(xs_ff[3]); dst_sel = 4'd6; end
         6'd22: begin a_sel = C_LAT_N2; b_sel = t_ff[0]; dst_sel = 4'd11; end
         6'd23: begin a_sel = t_ff[11]; b_sel = sx(xs_ff[4]); dst_sel = 4'd6; end
         6'd24: begin a_sel = gla; b_sel = t_ff[6]; d_sel = t_ff[8]; dst_sel = 4'd6; end
         // vertical axis, steps 25..40
         6'd25: begin a_sel = tauv; b_sel = tauv; dst_sel = 4'd0; end
         6'd26: begin a_sel = t_ff[0]; b_sel = tauv; dst_sel = 4'd7; end
         6'd27: begin a_sel = C_LAT_D3; b_sel = t_ff[7]; dst_sel = 4'd8; end
         6'd28: begin a_sel = C_LAT_D2; b_sel = t_ff[0]; dst_sel = 4'd9; end
         6'd29: begin a_sel = C_LAT_D1; b_sel = tauv; dst_sel = 4'd10; end
         6'd30: begin a_sel = t_ff[10]; b_sel = sx(xs_ff[6]); dst_sel = 4'd2; end
         6'd31: begin a_sel = t_ff[9]; b_sel = sx(xs_ff[7]); dst_sel = 4'd3; end
         6'd32: begin a_sel = t_ff[3]; b_sel = Q_ONE; d_sel = t_ff[8]; dst_sel = 4'd3; end
         6'd33: begin a_sel = sx(xs_ff[6]); b_sel = dt; dst_sel = 4'd4; end
         6'd34: begin a_sel = sx(xs_ff[7]); b_sel = dt; dst_sel = 4'd5; end
         6'd35: begin a_sel = t_ff[3]; b_sel = dt; dst_sel = 4'd3; end
         6'd36: begin a_sel = C_LAT_N1; b_sel = tauv; dst_sel = 4'd2; end
         6'd37: begin a_sel = t_ff[2]; b_sel = sx(xs_ff[6]); dst_sel = 4'd6; end
         6'd38: begin a_sel = C_LAT_N2; b_sel = t_ff[0]; dst_sel = 4'd11; end
         6'd39: begin a_sel = t_ff[11]; b_sel = sx(xs_ff[7]); dst_sel = 4'd6; end
         6'd40: begin a_sel = gv; b_sel = t_ff[6]; d_sel = t_ff[8]; dst_sel = 4'd6; end
         default: ;
      endcase
   end

   // Fold floors, sums and noise into the value written to scratch
   always_comb begin
      wb = res;
      unique case (step_ff)
         6'd1, 6'd11, 6'd27: wb = floor1(res);
         // numerator for longitudinal derivative
         6'd3:  wb = sadd(sneg(sx(xs_ff[0])), sneg(res));
         6'd4:  wb = sadd(res, 64'(word_ff.noise_long));
         6'd16: wb = sadd(res, 64'(word_ff.noise_lat));
         6'd32: wb = sadd(res, 64'(word_ff.noise_vert));
         6'd15: wb = sadd(sadd(sneg(sx(xs_ff[2])), sneg(t_ff[2])), sneg(res));
         6'd31: wb = sadd(sadd(sneg(sx(xs_ff[5])), sneg(t_ff[2])), sneg(res));
         6'd8:  wb = sadd(sx(xs_ff[0]), res);
         6'd21: wb = sadd(sx(xs_ff[2]), res);
         6'd37: wb = sadd(sx(xs_ff[5]), res);
         6'd23, 6'd39: wb = sadd(t_ff[6], res);
         default: ;
      endcase
   end

   assign md_req.start = (phase_ff == P_ISSUE);
   assign md_req.a = a_sel;
   assign md_req.b = b_sel;
   assign md_req.d = d_sel;
   assign res = md_rsp.q;

   assign req_stall = (phase_ff != P_IDLE);
   assign take      = req_valid && !req_stall;
   assign load_out  = (phase_ff == P_OUT) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      unique case (phase_ff)
         P_IDLE: if (take) begin
            phase_in = P_ISSUE; step_in = '0;
         end
         P_ISSUE: phase_in = P_WAIT;
         P_WAIT: if (md_rsp.done) begin
            if (step_ff == 6'(NSTEP - 1)) phase_in = P_OUT;
            else begin
               phase_in = P_ISSUE; step_in = step_ff + 6'd1;
            end
         end
         P_OUT: if (!out_valid_ff || !rsp_stall) phase_in = P_IDLE;
         default: phase_in = P_IDLE;
      endcase
   end

   // Write back results, with the clamps and state commits folded in
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         step_ff  <= '0;
         dt_ff    <= 16'd66;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) xs_ff[i] <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         if (csr_write) dt_ff <= csr_data;
         out_valid_ff <= load_out || (out_valid_ff && rsp_stall);
         if (phase_ff == P_WAIT && md_rsp.done) begin
            t_ff[dst_sel] <= wb;
            unique case (step_ff)
               6'd5: xs_ff[0] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[0]), res)));
               6'd6: xs_ff[1] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[1]), res)));
               6'd9: out_ff.turb_long <= 32'(to_out(res));
               6'd17: xs_ff[2] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[2]), res)));
               6'd18: xs_ff[3] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[3]), res)));
               6'd19: xs_ff[4] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[4]), res)));
               6'd24: out_ff.turb_lat <= 32'(to_out(res));
               6'd33: xs_ff[5] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[5]), res)));
               6'd34: xs_ff[6] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[6]), res)));
               6'd35: xs_ff[7] <= STATE_WIDTH'(clampst(sadd(sx(xs_ff[7]), res)));
               6'd40: out_ff.turb_vert <= 32'(to_out(res));
               default: ;
            endcase
         end
      end
      if (take) word_ff <= req_word;
   end

   // Hold the finished word until the receiver takes it
   always_ff @(posedge clock) begin
      if (load_out) rsp_word <= out_ff;
   end
   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   // no new word while one is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != P_IDLE) |-> req_stall)
      else $error("input taken while busy");
   // unit start only from issue phase, then waiting
   a_issue: assert property (@(posedge clock) disable iff (reset)
      md_req.start |=> (phase_ff == P_WAIT))
      else $error("issue not followed by wait");
   // result appears only after the last step
   a_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(phase_ff == P_OUT))
      else $error("result without finished program");
`endif

endmodule

`default_nettype wire

// ===== dv/vkt_filter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vkt_filter_checker: result predictor and comparator for the filter bank
// Watches both channels and the substep register port. Each accepted input
// word runs one Euler substep on its own copy of the three filters and
// queues the expected turbulence word; every accepted result word is
// compared field by field with the oldest queued word.
// ---------------------------------------------------------------------------
module vkt_filter_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  vkt_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  vkt_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write,
   input  logic [15:0]           csr_data,
   output int                    error_count,
   output int                    words_due
);
   import vkt_pkg::*;

   localparam longint SAT_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam int     STATE_BITS = 48;
   localparam longint STATE_MAX  = (64'sd1 <<< (STATE_BITS - 1)) - 1;
   localparam longint ONE_Q16    = 65536;
   localparam longint K_LONG_A2  = 13022;
   localparam longint K_LONG_A1  = 88932;
   localparam longint K_LONG_B1  = 16384;
   localparam longint K_LAT_D3   = 10086;
   localparam longint K_LAT_D2   = 129460;
   localparam longint K_LAT_D1   = 196333;
   localparam longint K_LAT_N1   = 180080;
   localparam longint K_LAT_N2   = 22269;
   localparam int     AXIS_LAT   = 0;
   localparam int     AXIS_VERT  = 1;

   longint       long_x [2];
   longint       cross_x [2][3];
   longint       step_dt;
   rsp_word_type turb_expected_q[$];

   // a*b/d exact, truncated toward zero, saturated to +-(2^63-1)
   function automatic longint scaled_div(longint a, longint b, longint unsigned d);
      logic [127:0]    prod;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned q;
      logic            neg;
      ma = a;
      mb = b;
      if (a < 0) ma = -ma;
      if (b < 0) mb = -mb;
      neg = (a < 0) != (b < 0);
      if (d == 0) d = 1;
      prod = {64'd0, ma} * {64'd0, mb};
      if (prod[127:64] >= d) q = '1;
      else q = 64'(prod / {64'd0, d});
      if (q > longint'(SAT_MAX)) q = SAT_MAX;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return scaled_div(a, b, ONE_Q16);
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      if (b > 0 && a > SAT_MAX - b) return SAT_MAX;
      if (b < 0 && a < -SAT_MAX - b) return -SAT_MAX;
      return a + b;
   endfunction

   function automatic longint sat_neg(longint a);
      if (a < -SAT_MAX) return SAT_MAX;
      return -a;
   endfunction

   function automatic longint state_clip(longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < -STATE_MAX - 1) return -STATE_MAX - 1;
      return v;
   endfunction

   function automatic logic signed [31:0] velocity_clip(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // One substep of the longitudinal second-order filter
   function automatic logic signed [31:0] long_substep(longint tau, longint gain,
                                                       longint w);
      longint tau2;
      longint lead;
      longint a1;
      longint num;
      longint deriv;
      longint n0;
      longint n1;
      tau2 = qmul(tau, tau);
      lead = qmul(K_LONG_A2, tau2);
      if (lead < 1) lead = 1;
      a1 = qmul(K_LONG_A1, tau);
      num = sat_sum(sat_neg(long_x[0]), sat_neg(qmul(a1, long_x[1])));
      deriv = sat_sum(scaled_div(num, ONE_Q16, lead), w);
      n0 = state_clip(sat_sum(long_x[0], qmul(long_x[1], step_dt)));
      n1 = state_clip(sat_sum(long_x[1], qmul(deriv, step_dt)));
      long_x[0] = n0;
      long_x[1] = n1;
      return velocity_clip(scaled_div(gain,
         sat_sum(n0, qmul(qmul(K_LONG_B1, tau), n1)), lead));
   endfunction

   // One substep of a lateral or vertical third-order filter
   function automatic logic signed [31:0] cross_substep(int ax, longint tau,
                                                        longint gain, longint w);
      longint tau2;
      longint tau3;
      longint lead;
      longint d2;
      longint d1;
      longint num;
      longint deriv;
      longint n0;
      longint n1;
      longint n2;
      tau2 = qmul(tau, tau);
      tau3 = qmul(tau2, tau);
      lead = qmul(K_LAT_D3, tau3);
      if (lead < 1) lead = 1;
      d2 = qmul(K_LAT_D2, tau2);
      d1 = qmul(K_LAT_D1, tau);
      num = sat_sum(sat_sum(sat_neg(cross_x[ax][0]), sat_neg(qmul(d1, cross_x[ax][1]))),
                    sat_neg(qmul(d2, cross_x[ax][2])));
      deriv = sat_sum(scaled_div(num, ONE_Q16, lead), w);
      n0 = state_clip(sat_sum(cross_x[ax][0], qmul(cross_x[ax][1], step_dt)));
      n1 = state_clip(sat_sum(cross_x[ax][1], qmul(cross_x[ax][2], step_dt)));
      n2 = state_clip(sat_sum(cross_x[ax][2], qmul(deriv, step_dt)));
      cross_x[ax][0] = n0;
      cross_x[ax][1] = n1;
      cross_x[ax][2] = n2;
      return velocity_clip(scaled_div(gain,
         sat_sum(sat_sum(n0, qmul(qmul(K_LAT_N1, tau), n1)),
                 qmul(qmul(K_LAT_N2, tau2), n2)), lead));
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         long_x = '{0, 0};
         cross_x = '{'{0, 0, 0}, '{0, 0, 0}};
         step_dt = 66;
         turb_expected_q.delete();
         error_count = 0;
      end else begin
         // update the substep length
         if (csr_write) step_dt = csr_data;

         // predict the word caused by an accepted input
         if (req_valid && !req_stall) begin
            want.turb_long = long_substep(req_word.tau_horizontal, req_word.gain_long,
                                          req_word.noise_long);
            want.turb_lat = cross_substep(AXIS_LAT, req_word.tau_horizontal,
                                          req_word.gain_lat, req_word.noise_lat);
            want.turb_vert = cross_substep(AXIS_VERT, req_word.tau_vertical,
                                           req_word.gain_vert, req_word.noise_vert);
            turb_expected_q.push_back(want);
         end

         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            if (turb_expected_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result word %h", got);
            end else begin
               want = turb_expected_q.pop_front();
               if (got.turb_long !== want.turb_long || got.turb_lat !== want.turb_lat ||
                   got.turb_vert !== want.turb_vert) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch: long %h/%h lat %h/%h vert %h/%h (exp/act)",
                              want.turb_long, got.turb_long, want.turb_lat,
                              got.turb_lat, want.turb_vert, got.turb_vert);
               end
            end
         end
      end
      words_due = turb_expected_q.size();
   end

endmodule

// ===== dv/von_karman_turbulence_filter_bank_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// von_karman_turbulence_filter_bank_tb: stimulus and verdict for the bank
// Drives edge-case words and then random words through several substep
// settings with random idle bursts on both channels and one long receiver
// hold-off; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module von_karman_turbulence_filter_bank_tb;
   import vkt_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int     PHASE_WORDS = 170;
   localparam int     HOLD_CYCLES = 20000;
   localparam int     DRAIN_WAIT  = 6000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_word;
   logic         csr_write = 0;
   logic [15:0]  csr_data = '0;
   int           error_count;
   int           words_due;
   int           words_sent = 0;
   logic         calm = 0;
   longint       cycles = 0;

   von_karman_turbulence_filter_bank dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   vkt_filter_checker turb_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_data(csr_data),
      .error_count(error_count), .words_due(words_due)
   );

   always #10 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off, none when calm
   always @(negedge clock) begin
      static int hold_left = 0;
      static int burst_left = 0;
      static logic held_once = 0;
      if (!held_once && words_sent >= 200) begin
         held_once = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall = 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(1, 11) - 1;
         rsp_stall = 1;
      end else begin
         rsp_stall = 0;
      end
   end

   // offer one word and hold it until taken, then maybe go idle
   task automatic offer_word(input req_word_type w);
      req_word = w;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   function automatic req_word_type edge_word(int i);
      logic [22:0]        taus [4]  = '{23'd0, 23'd1, 23'd65536, 23'h7FFFFF};
      logic [21:0]        gains [3] = '{22'd0, 22'd65536, 22'h3FFFFF};
      logic signed [31:0] noises [5] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0,
                                         -32'sd65536, 32'sd65536};
      req_word_type w;
      w.tau_horizontal = taus[i % 4];
      w.tau_vertical = taus[(i / 4) % 4];
      w.gain_long = gains[i % 3];
      w.gain_lat = gains[(i + 1) % 3];
      w.gain_vert = gains[(i + 2) % 3];
      w.noise_long = noises[i % 5];
      w.noise_lat = noises[(i + 2) % 5];
      w.noise_vert = noises[(i + 4) % 5];
      return w;
   endfunction

   // mostly realistic flight values, sometimes raw bits
   function automatic req_word_type random_word();
      req_word_type w;
      if ($urandom_range(0, 3) == 0) begin
         w.tau_horizontal = 23'($urandom);
         w.tau_vertical = 23'($urandom);
         w.gain_long = 22'($urandom);
         w.gain_lat = 22'($urandom);
         w.gain_vert = 22'($urandom);
         w.noise_long = $urandom;
         w.noise_lat = $urandom;
         w.noise_vert = $urandom;
      end else begin
         w.tau_horizontal = 23'($urandom_range(1, 4194304));
         w.tau_vertical = 23'($urandom_range(1, 4194304));
         w.gain_long = 22'($urandom_range(0, 2097152));
         w.gain_lat = 22'($urandom_range(0, 2097152));
         w.gain_vert = 22'($urandom_range(0, 2097152));
         w.noise_long = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         w.noise_lat = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         w.noise_vert = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      end
      return w;
   endfunction

   // write the substep length once the block is drained
   task automatic set_substep(input logic [15:0] dt);
      req_valid = 0;
      while (words_due != 0) @(negedge clock);
      csr_data = dt;
      csr_write = 1;
      @(negedge clock);
      csr_write = 0;
   endtask

   initial begin
      logic [15:0] substeps [6];
      substeps = '{16'd66, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd66};
      substeps[4] = 16'($urandom_range(1, 65535));
      repeat (4) @(negedge clock);
      reset = 0;

      // edge cases at the reset substep length
      for (int i = 0; i < 20; i++) offer_word(edge_word(i));

      // random words across substep settings; last phase without idling
      for (int p = 0; p < 6; p++) begin
         set_substep(substeps[p]);
         if (p == 5) calm = 1;
         for (int i = 0; i < PHASE_WORDS; i++) offer_word(random_word());
      end
      req_valid = 0;

      // drain and watch for stray results
      while (words_due != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/vkt_pkg.sv
hdl/vkt_muldiv.sv
hdl/von_karman_turbulence_filter_bank.sv
dv/vkt_filter_checker.sv
dv/von_karman_turbulence_filter_bank_tb.sv
